@@ hw/rtl/fwwt_pkg.sv @@
package fwwt_pkg;

  localparam int TABLE_ENTRIES     = 16;
  localparam int WAITERS_PER_ENTRY = 8;
  localparam int THREAD_ID_BITS    = 8;

  localparam int ENTRY_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_BITS  = (WAITERS_PER_ENTRY > 1) ? $clog2(WAITERS_PER_ENTRY) : 1;
  localparam int CNT_BITS   = $clog2(WAITERS_PER_ENTRY + 1);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_MISMATCH = 2'd1;
  localparam status_t ST_TBL_FULL = 2'd2;
  localparam status_t ST_SLOTS_FULL = 2'd3;

  localparam logic REQ_WAIT = 1'b0;
  localparam logic REQ_WAKE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_WAKE,
    S_OUT
  } state_t;

endpackage

@@ hw/rtl/fwwt_ram.sv @@
module fwwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/futex_wait_wake_table.sv @@
// Channel | Direction | Payload
// in_     | slave     | tdata: key, expected, current, thread_id; tuser: req_type
// out_    | master     | tdata: status, woken_valid, woken_thread, woken_count; tlast: last
// A wait, or a wake with no waiters, steps through S_READ, S_DECIDE and S_OUT.
// A wake with waiters steps through S_READ and S_DECIDE, then gives one S_WAKE result per released waiter.
// Each entry's waiter threads sit in one RAM row read once per request.
// Keys are matched in parallel in flip-flops; valid bits reset at once.
// One request at a time; the output register holds while out_tready is low.
module futex_wait_wake_table
  import fwwt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,  // key[63:0], expected[127:64], current[191:128], tid[199:192]
  input  logic         in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata, // status[1:0], woken_valid[2], woken_thread[10:3], count[17:11]
  output logic         out_tlast
);

  localparam int ROW_W = WAITERS_PER_ENTRY * THREAD_ID_BITS;

  state_t state_r, state_nxt;
  logic                         req_r;
  logic [63:0]                  key_r;
  logic                         match_r;
  logic [THREAD_ID_BITS-1:0]    tid_r;
  logic [TABLE_ENTRIES-1:0]     ev_r;
  logic [63:0]                  ekey_r [TABLE_ENTRIES];
  logic [WAITERS_PER_ENTRY-1:0] wv_r [TABLE_ENTRIES];
  logic [ENTRY_BITS-1:0]        ent_r;
  logic                         hit_r, free_r;
  logic [ROW_W-1:0]             row_r;
  logic [WAITERS_PER_ENTRY-1:0] pend_r;
  logic [CNT_BITS-1:0]          cnt_r;
  logic [23:0]                  od_r;
  logic                         ol_r, ov_r;

  logic                         ram_we;
  logic [ENTRY_BITS-1:0]        ram_raddr;
  logic [ROW_W-1:0]             ram_wdata, ram_rdata;

  fwwt_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ent_r), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic                  hit_c, free_c;
  logic [ENTRY_BITS-1:0] hidx_c, fidx_c;
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hidx_c = '0; fidx_c = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ev_r[i] && ekey_r[i] == key_r) begin
        hit_c = 1'b1; hidx_c = ENTRY_BITS'(i);
      end
      if (!ev_r[i]) begin
        free_c = 1'b1; fidx_c = ENTRY_BITS'(i);
      end
    end
  end

  assign ram_raddr = (state_r == S_READ) ? (hit_c ? hidx_c : fidx_c) : ent_r;

  logic                 slot_c;
  logic [SLOT_BITS-1:0] sidx_c;
  always_comb begin
    slot_c = 1'b0; sidx_c = '0;
    for (int j = WAITERS_PER_ENTRY - 1; j >= 0; j--) begin
      if (!wv_r[ent_r][j]) begin
        slot_c = 1'b1; sidx_c = SLOT_BITS'(j);
      end
    end
  end

  logic [SLOT_BITS-1:0] pidx_c;
  logic                 plast_c;
  always_comb begin
    pidx_c = '0;
    for (int j = WAITERS_PER_ENTRY - 1; j >= 0; j--) begin
      if (pend_r[j]) pidx_c = SLOT_BITS'(j);
    end
    plast_c = ($countones(pend_r) == 1);
  end

  function automatic logic [23:0] pack(status_t st, logic wv, logic [7:0] wt,
                                       logic [6:0] c);
    pack = {6'd0, c, wt, wv, st};
  endfunction

  logic out_free;
  logic ov_load;
  assign out_free  = !ov_r || out_tready;
  assign ov_load   = (state_r == S_WAKE || state_r == S_OUT) && out_free;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    ram_wdata[sidx_c*THREAD_ID_BITS +: THREAD_ID_BITS] = tid_r;
    case (state_r)
      S_IDLE:   if (in_tvalid && in_tready) state_nxt = S_READ;
      S_READ:   state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (req_r == REQ_WAKE && hit_r && wv_r[ent_r] != '0) state_nxt = S_WAKE;
        else state_nxt = S_OUT;
        if (req_r == REQ_WAIT && match_r && (hit_r || free_r) && slot_c) ram_we = 1'b1;
      end
      S_WAKE:   if (out_free && plast_c) state_nxt = S_IDLE;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ev_r    <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) wv_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_load || (ov_r && !out_tready);
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          req_r   <= in_tuser;
          key_r   <= in_tdata[63:0];
          match_r <= (in_tdata[127:64] == in_tdata[191:128]);
          tid_r   <= in_tdata[192 +: THREAD_ID_BITS];
        end
        S_READ: begin
          hit_r <= hit_c;
          free_r <= free_c;
          ent_r <= hit_c ? hidx_c : fidx_c;
        end
        S_DECIDE: begin
          row_r  <= ram_rdata;
          pend_r <= wv_r[ent_r];
          cnt_r  <= '0;
          if (req_r == REQ_WAKE) begin
            od_r <= pack(ST_OK, 1'b0, 8'd0, 7'd0);
          end else if (!match_r) begin
            od_r <= pack(ST_MISMATCH, 1'b0, 8'd0, 7'd0);
          end else if (!hit_r && !free_r) begin
            od_r <= pack(ST_TBL_FULL, 1'b0, 8'd0, 7'd0);
          end else begin
            if (!hit_r) begin
              ev_r[ent_r]   <= 1'b1;
              ekey_r[ent_r] <= key_r;
            end
            if (slot_c) begin
              wv_r[ent_r][sidx_c] <= 1'b1;
              od_r <= pack(ST_OK, 1'b0, 8'd0, 7'd0);
            end else begin
              od_r <= pack(ST_SLOTS_FULL, 1'b0, 8'd0, 7'd0);
            end
          end
          ol_r <= 1'b1;
        end
        S_WAKE: if (out_free) begin
          ol_r <= plast_c;
          od_r <= pack(ST_OK, 1'b1,
                       8'(row_r[pidx_c*THREAD_ID_BITS +: THREAD_ID_BITS]),
                       7'(cnt_r + 1'b1));
          cnt_r <= cnt_r + 1'b1;
          pend_r[pidx_c] <= 1'b0;
          wv_r[ent_r][pidx_c] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/fwwt_checker.sv @@
module fwwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_wake_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == 2'd0 && out_tdata[17:11] != 7'd0)
    else $error("bad wake result");

  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tlast && out_tdata[17:3] == 15'd0)
    else $error("bad single result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");

endmodule

bind futex_wait_wake_table fwwt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

@@ sim/futex_table_checker.sv @@
`timescale 1ns / 1ps

module futex_table_checker
  import fwwt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [199:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count
);

  localparam int SLOTS = TABLE_ENTRIES * WAITERS_PER_ENTRY;

  typedef struct packed {
    logic [1:0] status;
    logic       woken_valid;
    logic [7:0] woken_thread;
    logic [6:0] woken_count;
    logic       last;
  } futex_result_t;

  logic        ent_valid [TABLE_ENTRIES];
  logic [63:0] ent_key   [TABLE_ENTRIES];
  logic        slot_busy [SLOTS];
  logic [7:0]  slot_tid  [SLOTS];

  futex_result_t expected_results[$];

  function automatic futex_result_t make_result(logic [1:0] st, logic wv, logic [7:0] wt,
                                                logic [6:0] cnt, logic lst);
    futex_result_t r;
    r.status = st;
    r.woken_valid = wv;
    r.woken_thread = wt;
    r.woken_count = cnt;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_entry(logic [63:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (ent_valid[i] && ent_key[i] == key) return i;
    return -1;
  endfunction

  task automatic apply_request(logic req, logic [199:0] d);
    logic [63:0] key;
    logic [7:0]  tid;
    int          e;
    int          total;
    int          n;
    bit          queued;
    key = d[63:0];
    tid = d[199:192] & 8'((1 << THREAD_ID_BITS) - 1);
    if (req == REQ_WAIT) begin
      if (d[127:64] != d[191:128]) begin
        expected_results.push_back(make_result(ST_MISMATCH, 1'b0, 8'd0, 7'd0, 1'b1));
        return;
      end
      e = lookup_entry(key);
      if (e < 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (!ent_valid[i]) begin
            e = i;
            break;
          end
        if (e < 0) begin
          expected_results.push_back(make_result(ST_TBL_FULL, 1'b0, 8'd0, 7'd0, 1'b1));
          return;
        end
        ent_valid[e] = 1;
        ent_key[e] = key;
      end
      queued = 0;
      for (int i = 0; i < WAITERS_PER_ENTRY; i++) begin
        if (!queued && !slot_busy[e * WAITERS_PER_ENTRY + i]) begin
          slot_busy[e * WAITERS_PER_ENTRY + i] = 1;
          slot_tid[e * WAITERS_PER_ENTRY + i] = tid;
          queued = 1;
        end
      end
      expected_results.push_back(make_result(queued ? ST_OK : ST_SLOTS_FULL, 1'b0, 8'd0,
                                             7'd0, 1'b1));
    end else begin
      e = lookup_entry(key);
      total = 0;
      if (e >= 0)
        for (int i = 0; i < WAITERS_PER_ENTRY; i++)
          if (slot_busy[e * WAITERS_PER_ENTRY + i]) total++;
      if (total == 0) begin
        expected_results.push_back(make_result(ST_OK, 1'b0, 8'd0, 7'd0, 1'b1));
        return;
      end
      n = 0;
      for (int i = 0; i < WAITERS_PER_ENTRY; i++) begin
        if (slot_busy[e * WAITERS_PER_ENTRY + i]) begin
          slot_busy[e * WAITERS_PER_ENTRY + i] = 0;
          n++;
          expected_results.push_back(make_result(ST_OK, 1'b1,
                                                 slot_tid[e * WAITERS_PER_ENTRY + i],
                                                 7'(n), n == total));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    futex_result_t got;
    futex_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_valid[i] = 0;
        ent_key[i] = 0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] = 0;
        slot_tid[i] = 0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got = make_result(out_tdata[1:0], out_tdata[2], out_tdata[10:3], out_tdata[17:11],
                          out_tlast);
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: %h", got);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
          if (got.woken_valid != want.woken_valid) begin
            $error("woken_valid: expected %0d, actual %0d", want.woken_valid, got.woken_valid);
            errs++;
          end
          if (got.woken_thread != want.woken_thread) begin
            $error("woken_thread: expected %0d, actual %0d", want.woken_thread,
                   got.woken_thread);
            errs++;
          end
          if (got.woken_count != want.woken_count) begin
            $error("woken_count: expected %0d, actual %0d", want.woken_count, got.woken_count);
            errs++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata);
      fail_count <= fail_count + errs;
    end
    pending_count <= expected_results.size();
  end

endmodule

@@ sim/tb_futex_wait_wake_table.sv @@
`timescale 1ns / 1ps

module tb_futex_wait_wake_table;
  import fwwt_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           pending_count;
  int           idle_cycles;
  logic [63:0]  key_pool [24];

  futex_wait_wake_table dut (.*);

  futex_table_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send(logic req, logic [63:0] key, logic [63:0] expv, logic [63:0] curv,
                      logic [7:0] tid);
    int g;
    g = gap_length();
    @(negedge clk);
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata <= {tid, curv, expv, key};
    in_tuser <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_wait(logic [63:0] key, logic [7:0] tid);
    logic [63:0] v;
    v = rand64();
    send(REQ_WAIT, key, v, v, tid);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= ($urandom_range(0, 29) == 0) ? 1'b0 : 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_WAIT;
    for (int i = 0; i < 24; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(REQ_WAKE, key_pool[0], '0, '0, '0);
    send(REQ_WAIT, key_pool[0], '0, '1, 8'hff);
    send(REQ_WAIT, key_pool[0], '1, '1, 8'hff);
    send(REQ_WAIT, key_pool[0], '0, '0, 8'h00);
    for (int i = 0; i < WAITERS_PER_ENTRY; i++) send_wait(key_pool[1], 8'(i * 37 + 5));
    send_wait(key_pool[1], 8'haa);
    send(REQ_WAKE, key_pool[1], rand64(), rand64(), 8'($urandom));
    send(REQ_WAKE, key_pool[1], '0, '0, '0);
    send(REQ_WAKE, key_pool[0], '1, '0, 8'h55);
    for (int i = 2; i < TABLE_ENTRIES + 1; i++) send_wait(key_pool[i], 8'(i));
    send_wait(rand64(), 8'h11);
    send(REQ_WAKE, rand64(), '0, '0, '0);
    drain();

    for (int n = 0; n < 360; n++) begin
      k = $urandom_range(0, 19);
      case ($urandom_range(0, 9))
        0: send(REQ_WAIT, key_pool[k], rand64(), rand64(), 8'($urandom));
        1: send(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(), 8'($urandom));
        2, 3, 4: send(REQ_WAKE, key_pool[k], rand64(), rand64(), 8'($urandom));
        default: send_wait(key_pool[k], 8'($urandom));
      endcase
      if (n == 180) drain();
    end
    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
